// File: design/hex_command_frame_encoder_core_macros.svh
// Assertion macros shared by the encoder RTL.
`ifndef HEX_COMMAND_FRAME_ENCODER_CORE_MACROS_SVH
`define HEX_COMMAND_FRAME_ENCODER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define HCFE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define HCFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCFE_ASSERT(lbl, clk, rst, prop, msg)
`define HCFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/hcfe_pkg.sv
package hcfe_pkg;

   localparam int CMD_W   = 4;
   localparam int ID_W    = 16;
   localparam int VALUE_W = 32;
   localparam int SEL_W   = 2;
   localparam int CHAR_W  = 8;

   typedef logic [3:0]        nibble_type;
   typedef logic [CHAR_W-1:0] char_type;

   localparam char_type CHAR_COLON   = 8'h3A;
   localparam char_type CHAR_NEWLINE = 8'h0A;
   localparam char_type CHAR_ZERO    = 8'h30;
   localparam char_type CHAR_UPPER_A = 8'h41;
   localparam char_type CHECK_BASE   = 8'h55;

   // value width codes
   localparam logic [SEL_W-1:0] WIDTH_BYTE = 2'd0;
   localparam logic [SEL_W-1:0] WIDTH_HALF = 2'd1;
   localparam logic [SEL_W-1:0] WIDTH_WORD = 2'd2;

   // Map one nibble to its uppercase hex character.
   function automatic char_type hex_char(input nibble_type n);
      char_type c;
      if (n < 4'd10) begin
         c = CHAR_ZERO + {4'd0, n};
      end else begin
         c = CHAR_UPPER_A + {4'd0, n - 4'd10};
      end
      return c;
   endfunction

endpackage

// File: design/hcfe_if.sv
interface hcfe_req_if import hcfe_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command_code;
   logic [ID_W-1:0]    register_id;
   logic [VALUE_W-1:0] payload_value;
   logic [SEL_W-1:0]   payload_width;

   modport source (output valid, command_code, register_id, payload_value, payload_width,
                   input ready);
   modport sink   (input valid, command_code, register_id, payload_value, payload_width,
                   output ready);
endinterface

interface hcfe_rsp_if import hcfe_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] ascii_char;
   logic              frame_end;

   modport source (output valid, ascii_char, frame_end, input ready);
   modport sink   (input valid, ascii_char, frame_end, output ready);
endinterface

// File: design/hex_command_frame_encoder_core.sv
// ASCII hex command frame encoder.
// req_if takes one command item (command_code, register_id, payload_value,
// payload_width); rsp_if returns the frame one character per item: colon,
// command digit, id bytes low first, flags "00", value bytes low first,
// checksum (0x55 minus the byte sum), newline. frame_end marks the newline.
// A frame is 13, 15 or 19 characters for widths 0, 1, 2; 11 for width 3.
// A taken request loads the digit shift register and enters the START state,
// which puts the colon into the output register; with rsp_if.ready held high
// one character follows per cycle, and req_if.ready rises at the same edge
// that loads the newline into the output register. The rate is set by the
// nibble shift register that emits one hex digit per cycle while the output
// is not stalled, and the single output register in front of rsp_if.
// When the receiver stalls, the output register holds its character and the
// digit shifter waits. Reset (synchronous) drops any frame in progress and
// empties the output register; the block is ready on the next cycle.
`include "hex_command_frame_encoder_core_macros.svh"

module hex_command_frame_encoder_core import hcfe_pkg::*; (
   input logic         clock,
   input logic         reset,
   hcfe_req_if.sink    req_if,
   hcfe_rsp_if.source  rsp_if
);

   localparam int DIGITS   = 15;
   localparam int SHIFT_W  = DIGITS * 4;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_DATA  = 3'd2;
   localparam logic [2:0] ST_CK_HI = 3'd3;
   localparam logic [2:0] ST_CK_LO = 3'd4;
   localparam logic [2:0] ST_STOP  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [3:0]         count_ff, count_in;
   logic [7:0]         sum_ff, sum_in;
   logic               high_ff, high_in;
   logic               rsp_valid_ff, rsp_valid_in;
   char_type           char_ff, char_in;
   logic               end_ff, end_in;

   logic       req_take;
   logic       advance;
   nibble_type top_digit;
   char_type   check_byte;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign advance      = (state_ff != ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign top_digit    = shift_ff[SHIFT_W-1 -: 4];
   assign check_byte   = CHECK_BASE - sum_ff;

   // Sequence the frame, one character per advance.
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      high_in      = high_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      char_in      = char_ff;
      end_in       = end_ff;

      if (req_take) begin
         // load digits in send order: command, id low byte, id high byte, flags, value
         shift_in = {req_if.command_code,
                     req_if.register_id[7:4],     req_if.register_id[3:0],
                     req_if.register_id[15:12],   req_if.register_id[11:8],
                     4'h0, 4'h0,
                     req_if.payload_value[7:4],   req_if.payload_value[3:0],
                     req_if.payload_value[15:12], req_if.payload_value[11:8],
                     req_if.payload_value[23:20], req_if.payload_value[19:16],
                     req_if.payload_value[31:28], req_if.payload_value[27:24]};
         case (req_if.payload_width)
            WIDTH_BYTE: count_in = 4'd9;
            WIDTH_HALF: count_in = 4'd11;
            WIDTH_WORD: count_in = 4'd15;
            default:    count_in = 4'd7;
         endcase
         sum_in   = 8'd0;
         high_in  = 1'b0;
         state_in = ST_START;
      end else if (advance) begin
         rsp_valid_in = 1'b1;
         end_in       = 1'b0;
         case (state_ff)
            ST_START: begin
               char_in  = CHAR_COLON;
               state_in = ST_DATA;
            end
            ST_DATA: begin
               // emit top digit and fold it into the byte sum
               char_in  = hex_char(top_digit);
               sum_in   = high_ff ? sum_ff + {top_digit, 4'h0} : sum_ff + {4'h0, top_digit};
               high_in  = !high_ff;
               shift_in = {shift_ff[SHIFT_W-5:0], 4'h0};
               count_in = count_ff - 4'd1;
               if (count_ff == 4'd1) begin
                  state_in = ST_CK_HI;
               end
            end
            ST_CK_HI: begin
               char_in  = hex_char(check_byte[7:4]);
               state_in = ST_CK_LO;
            end
            ST_CK_LO: begin
               char_in  = hex_char(check_byte[3:0]);
               state_in = ST_STOP;
            end
            ST_STOP: begin
               char_in  = CHAR_NEWLINE;
               end_in   = 1'b1;
               state_in = ST_IDLE;
            end
            default: begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      count_ff <= count_in;
      sum_ff   <= sum_in;
      high_ff  <= high_in;
      char_ff  <= char_in;
      end_ff   <= end_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ascii_char = char_ff;
   assign rsp_if.frame_end  = end_ff;

   `HCFE_ASSERT(a_take_starts_frame, clock, reset,
      req_take |=> (state_ff == ST_START),
      "accepted item did not start a frame")
   `HCFE_ASSERT(a_end_is_newline, clock, reset,
      (rsp_valid_ff && end_ff) |-> (char_ff == CHAR_NEWLINE),
      "frame end on a character other than newline")
   `HCFE_ASSERT(a_data_has_digits, clock, reset,
      (state_ff == ST_DATA) |-> (count_ff != 4'd0),
      "digit state entered with no digits left")
   `HCFE_ASSERT_ALWAYS(a_reset_empties, clock,
      reset |=> (!rsp_valid_ff && state_ff == ST_IDLE),
      "reset left a frame in progress")

endmodule

// File: tb/tb_hex_command_frame_encoder_core.sv
`timescale 1ns / 1ps

module tb_hex_command_frame_encoder_core;
   import hcfe_pkg::*;

   // width code with no value bytes in the frame
   localparam logic [SEL_W-1:0] WIDTH_NONE = 2'd3;
   localparam int RANDOM_REQUESTS = 109;
   localparam int REQUESTS_PER_MODE = 16;

   typedef struct packed {
      logic [CMD_W-1:0]   command_code;
      logic [ID_W-1:0]    register_id;
      logic [VALUE_W-1:0] payload_value;
      logic [SEL_W-1:0]   payload_width;
   } command_request_type;

   typedef struct packed {
      char_type ascii_char;
      logic     frame_end;
   } frame_char_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic clock;
   logic reset;

   hcfe_req_if req_ch ();
   hcfe_rsp_if rsp_ch ();

   hex_command_frame_encoder_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   command_request_type pending_requests[$];
   frame_char_type      frame_chars_due[$];
   idle_mode_type       idle_mode;
   int                  requests_taken;
   int                  mismatches;

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
   endtask

   function automatic char_type nibble_to_ascii(input logic [3:0] n);
      char_type c;
      if (n < 4'd10) begin
         c = CHAR_ZERO + {4'd0, n};
      end else begin
         c = CHAR_UPPER_A + {4'd0, n} - 8'd10;
      end
      return c;
   endfunction

   // Queue one byte as two hex digits, high nibble first.
   task automatic push_hex_byte(input logic [7:0] b);
      frame_chars_due.push_back('{nibble_to_ascii(b[7:4]), 1'b0});
      frame_chars_due.push_back('{nibble_to_ascii(b[3:0]), 1'b0});
   endtask

   // Queue the whole frame that one command request should produce.
   task automatic predict_frame(input command_request_type r);
      int       value_bytes;
      logic [7:0] byte_sum;
      logic [7:0] b;
      case (r.payload_width)
         WIDTH_BYTE: value_bytes = 1;
         WIDTH_HALF: value_bytes = 2;
         WIDTH_WORD: value_bytes = 4;
         default:    value_bytes = 0;
      endcase
      frame_chars_due.push_back('{CHAR_COLON, 1'b0});
      frame_chars_due.push_back('{nibble_to_ascii(r.command_code), 1'b0});
      byte_sum = {4'd0, r.command_code};
      byte_sum += r.register_id[7:0];
      push_hex_byte(r.register_id[7:0]);
      byte_sum += r.register_id[15:8];
      push_hex_byte(r.register_id[15:8]);
      // flags byte is always zero
      push_hex_byte(8'h00);
      for (int i = 0; i < value_bytes; i++) begin
         b = r.payload_value[8*i +: 8];
         byte_sum += b;
         push_hex_byte(b);
      end
      push_hex_byte(CHECK_BASE - byte_sum);
      frame_chars_due.push_back('{CHAR_NEWLINE, 1'b1});
   endtask

   // Clock, and known levels on every input from time zero.
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command_code = '0;
      req_ch.register_id = '0;
      req_ch.payload_value = '0;
      req_ch.payload_width = '0;
      rsp_ch.ready = 1'b0;
      forever #10 clock = ~clock;
   end

   // Driver: present queued requests, predict each frame on acceptance.
   always @(posedge clock) begin : request_driver
      command_request_type next_req;
      command_request_type taken;
      int idle_pct;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken = '{req_ch.command_code, req_ch.register_id,
                      req_ch.payload_value, req_ch.payload_width};
            predict_frame(taken);
            requests_taken++;
            idle_mode <= idle_mode_type'((requests_taken / REQUESTS_PER_MODE) % 4);
         end
         if (!req_ch.valid || req_ch.ready) begin
            case (idle_mode)
               IDLE_SENDER: idle_pct = 65;
               IDLE_BOTH:   idle_pct = 20;
               default:     idle_pct = 0;
            endcase
            if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               next_req = pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.command_code <= next_req.command_code;
               req_ch.register_id <= next_req.register_id;
               req_ch.payload_value <= next_req.payload_value;
               req_ch.payload_width <= next_req.payload_width;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each character against the oldest one due.
   always @(posedge clock) begin : frame_monitor
      frame_char_type due;
      int stall_pct;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_chars_due.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h frame_end %0b",
                                         rsp_ch.ascii_char, rsp_ch.frame_end));
            end else begin
               due = frame_chars_due.pop_front();
               if (rsp_ch.ascii_char !== due.ascii_char) begin
                  report_mismatch($sformatf("ascii_char 0x%02h, want 0x%02h",
                                            rsp_ch.ascii_char, due.ascii_char));
               end
               if (rsp_ch.frame_end !== due.frame_end) begin
                  report_mismatch($sformatf("frame_end %0b, want %0b (char 0x%02h)",
                                            rsp_ch.frame_end, due.frame_end,
                                            due.ascii_char));
               end
            end
         end
         case (idle_mode)
            IDLE_RECEIVER: stall_pct = 65;
            IDLE_BOTH:     stall_pct = 20;
            default:       stall_pct = 0;
         endcase
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      command_request_type r;
      idle_mode = IDLE_NONE;
      requests_taken = 0;
      mismatches = 0;

      // every command, every width code, id and value extremes
      for (int i = 0; i < 16; i++) begin
         r.command_code = CMD_W'(i);
         r.payload_width = SEL_W'(i % 4);
         case (i % 3)
            0:       r.register_id = 16'h0000;
            1:       r.register_id = 16'hFFFF;
            default: r.register_id = 16'hA5C3 ^ ID_W'(i);
         endcase
         case (i / 4)
            0:       r.payload_value = 32'h0000_0000;
            1:       r.payload_value = 32'hFFFF_FFFF;
            2:       r.payload_value = 32'h1234_5678;
            default: r.payload_value = 32'h80FF_0001;
         endcase
         pending_requests.push_back(r);
      end
      // checksum of zero and of 0xFF, no value bytes
      pending_requests.push_back('{4'h5, 16'h0050, 32'hDEAD_BEEF, WIDTH_NONE});
      pending_requests.push_back('{4'h6, 16'h0050, 32'h0000_0000, WIDTH_NONE});
      // value wider than the selected width, and an all-ones word
      pending_requests.push_back('{4'h8, 16'h1234, 32'hFFFF_FF7F, WIDTH_BYTE});
      pending_requests.push_back('{4'h7, 16'hFF00, 32'hFFFF_00FF, WIDTH_HALF});
      pending_requests.push_back('{4'hF, 16'hFFFF, 32'hFFFF_FFFF, WIDTH_WORD});

      // random requests, mostly with real value widths
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         r.command_code = CMD_W'($urandom_range(15));
         r.register_id = ID_W'($urandom);
         r.payload_value = $urandom;
         r.payload_width = ($urandom_range(9) == 0) ? WIDTH_NONE : SEL_W'($urandom_range(2));
         pending_requests.push_back(r);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain: all requests taken, all characters seen, then a short tail
      while (pending_requests.size() != 0 || req_ch.valid) @(posedge clock);
      while (frame_chars_due.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard stop if the block hangs.
   initial begin : watchdog
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
